FILE: rtl/core/ggp_pkg.sv
// Shared types and constants for the GGA position parser.
// Used by ggp_parser, ggp_result and nmea_gga_position_parser; no dependencies.
package ggp_pkg;

  localparam int LAT_W     = 31;  // latitude_e7 result width
  localparam int LON_W     = 32;  // longitude_e7 result width
  localparam int ALT_W     = 28;  // altitude_mm result width
  localparam int DEG_W     = 10;  // whole degrees of one coordinate
  localparam int MIN_W     = 24;  // minutes in units of 1e-5 minute
  localparam int ALT_MAG_W = 27;  // altitude magnitude in mm, at most 1e8
  localparam int LIMIT_W   = 10;  // idle_limit register width

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 10'd50;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_IDLE_LIMIT = 3'd0;

  // Snapshot of one completed fix, handed from the parser to the result pipeline.
  typedef struct packed {
    logic [DEG_W-1:0]     lat_deg;
    logic [MIN_W-1:0]     lat_min;
    logic [DEG_W-1:0]     lon_deg;
    logic [MIN_W-1:0]     lon_min;
    logic                 south;
    logic                 west;
    logic [ALT_MAG_W-1:0] alt_mag;
    logic                 alt_neg;
  } fix_t;

endpackage

FILE: rtl/core/ggp_parser.sv
// Burst tracking and byte-by-byte GGA field parsing.
// Depends on ggp_pkg for fix_t and field widths.
module ggp_parser #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         op_tick,
  input  logic [7:0]                   byte_value,
  input  logic [ggp_pkg::LIMIT_W-1:0]  idle_limit,
  output logic                         emit,
  output ggp_pkg::fix_t                fix
);

  localparam int BW = $clog2(BUFFER_BYTES - 1);
  localparam logic [BW-1:0] BURST_MAX = BW'(BUFFER_BYTES - 2);

  localparam logic [2:0] HDR_LEN = 3'd7;
  localparam logic [2:0] FD_STOP = 3'd7;

  localparam logic [3:0] FIELD_FIRST = 4'd1;
  localparam logic [3:0] FIELD_LAT   = 4'd2;
  localparam logic [3:0] FIELD_NS    = 4'd3;
  localparam logic [3:0] FIELD_LON   = 4'd4;
  localparam logic [3:0] FIELD_EW    = 4'd5;
  localparam logic [3:0] FIELD_ALT   = 4'd9;
  localparam logic [3:0] FIELD_LAST  = 4'd14;
  localparam logic [3:0] FIELD_DONE  = 4'd15;
  localparam logic [3:0] CHARS_MAX   = 4'd15;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam logic [ggp_pkg::MIN_W-1:0] MIN_SAT = '1;
  localparam logic [ggp_pkg::ALT_MAG_W-1:0] ALT_SAT = 27'd100000000;

  typedef struct packed {
    logic [ggp_pkg::MIN_W-1:0] acc;
    logic [2:0]                fd;
  } feed_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = 8'h47;  // G
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h47;  // G
      3'd4:    ch = 8'h47;  // G
      3'd5:    ch = 8'h41;  // A
      3'd6:    ch = CH_COMMA;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  // One character of the minutes: integer digits scale by ten, up to five
  // fraction digits after a point add at decreasing weight, others stop the number.
  function automatic feed_t minutes_feed(input feed_t cur, input logic [7:0] ch);
    feed_t       res;
    logic [27:0] v;
    logic [27:0] w;
    res = cur;
    v   = 28'(cur.acc);
    unique case (cur.fd)
      3'd1:    w = 28'd10000;
      3'd2:    w = 28'd1000;
      3'd3:    w = 28'd100;
      3'd4:    w = 28'd10;
      default: w = 28'd1;
    endcase
    if (cur.fd != FD_STOP) begin
      if (is_digit(ch)) begin
        if (cur.fd == 3'd0) begin
          v = 28'(cur.acc) * 28'd10 + 28'(ch[3:0]) * 28'd100000;
        end else if (cur.fd <= 3'd5) begin
          v = 28'(cur.acc) + 28'(ch[3:0]) * w;
          res.fd = cur.fd + 3'd1;
        end
        res.acc = (v > 28'(MIN_SAT)) ? MIN_SAT : v[ggp_pkg::MIN_W-1:0];
      end else if (ch == CH_DOT && cur.fd == 3'd0) begin
        res.fd = 3'd1;
      end else begin
        res.fd = FD_STOP;
      end
    end
    return res;
  endfunction

  logic [BW-1:0]                 burst_bytes, burst_bytes_next;
  logic [ggp_pkg::LIMIT_W-1:0]   idle_ticks, idle_ticks_next;
  logic [2:0]                    header_progress, header_progress_next;
  logic                          header_found, header_found_next;
  logic [3:0]                    field_number, field_number_next;
  logic [3:0]                    field_chars, field_chars_next;
  logic [7:0]                    coord_head [4];
  logic [ggp_pkg::DEG_W-1:0]     lat_degrees, lat_degrees_next;
  logic [ggp_pkg::MIN_W-1:0]     lat_minutes_e5, lat_minutes_e5_next;
  logic [ggp_pkg::DEG_W-1:0]     lon_degrees, lon_degrees_next;
  logic [ggp_pkg::MIN_W-1:0]     lon_minutes_e5, lon_minutes_e5_next;
  logic                          south, south_next;
  logic                          west, west_next;
  logic [ggp_pkg::ALT_MAG_W-1:0] altitude_accum, altitude_accum_next;
  logic                          altitude_negative, altitude_negative_next;
  logic [2:0]                    fraction_digits, fraction_digits_next;

  logic                      lat_short, lon_short;
  logic                      three_deg;
  logic [ggp_pkg::DEG_W-1:0] deg_calc;
  feed_t                     head_f1, head_f2, head_f3, feed_cur;
  logic [30:0]               alt_v;
  logic [30:0]               alt_w;
  logic                      parse_byte;

  // A coordinate field of five or fewer characters reads as zero when it closes.
  assign lat_short = (field_number == FIELD_LAT) && (field_chars <= 4'd5);
  assign lon_short = (field_number == FIELD_LON) && (field_chars <= 4'd5);

  // Degrees and leading minutes once the fifth character arrives.
  assign three_deg = (byte_value != CH_DOT);
  always_comb begin
    if (!is_digit(coord_head[0])) begin
      deg_calc = '0;
    end else if (!is_digit(coord_head[1])) begin
      deg_calc = 10'(coord_head[0][3:0]);
    end else if (!three_deg || !is_digit(coord_head[2])) begin
      deg_calc = 10'(coord_head[0][3:0]) * 10'd10 + 10'(coord_head[1][3:0]);
    end else begin
      deg_calc = 10'(coord_head[0][3:0]) * 10'd100 + 10'(coord_head[1][3:0]) * 10'd10
               + 10'(coord_head[2][3:0]);
    end
  end

  assign head_f1  = minutes_feed('0, three_deg ? coord_head[3] : coord_head[2]);
  assign head_f2  = minutes_feed(head_f1, three_deg ? byte_value : coord_head[3]);
  assign head_f3  = three_deg ? head_f2 : minutes_feed(head_f2, byte_value);
  assign feed_cur = minutes_feed('{acc: (field_number == FIELD_LAT) ? lat_minutes_e5
                                                                    : lon_minutes_e5,
                                   fd: fraction_digits}, byte_value);

  always_comb begin
    unique case (fraction_digits)
      3'd1:    alt_w = 31'd100;
      3'd2:    alt_w = 31'd10;
      default: alt_w = 31'd1;
    endcase
  end

  // The fix as it stands when the burst closes, with the open field finished.
  always_comb begin
    fix.lat_deg = lat_short ? '0 : lat_degrees;
    fix.lat_min = lat_short ? '0 : lat_minutes_e5;
    fix.lon_deg = lon_short ? '0 : lon_degrees;
    fix.lon_min = lon_short ? '0 : lon_minutes_e5;
    fix.south   = south;
    fix.west    = west;
    fix.alt_mag = altitude_accum;
    fix.alt_neg = altitude_negative;
  end

  assign parse_byte = accept && !op_tick && (burst_bytes < BURST_MAX);

  always_comb begin
    burst_bytes_next       = burst_bytes;
    idle_ticks_next        = idle_ticks;
    header_progress_next   = header_progress;
    header_found_next      = header_found;
    field_number_next      = field_number;
    field_chars_next       = field_chars;
    lat_degrees_next       = lat_degrees;
    lat_minutes_e5_next    = lat_minutes_e5;
    lon_degrees_next       = lon_degrees;
    lon_minutes_e5_next    = lon_minutes_e5;
    south_next             = south;
    west_next              = west;
    altitude_accum_next    = altitude_accum;
    altitude_negative_next = altitude_negative;
    fraction_digits_next   = fraction_digits;
    alt_v                  = 31'(altitude_accum);
    emit                   = 1'b0;

    if (accept && !op_tick) begin
      idle_ticks_next = '0;
    end

    if (parse_byte) begin
      burst_bytes_next = burst_bytes + BW'(1);
      if (!header_found) begin
        if (header_progress != HDR_LEN) begin
          if (byte_value == CH_NUL) begin
            header_progress_next = HDR_LEN;
          end else if (byte_value == hdr_char(header_progress)) begin
            header_progress_next = header_progress + 3'd1;
            if (header_progress == HDR_LEN - 3'd1) begin
              header_found_next    = 1'b1;
              field_number_next    = FIELD_FIRST;
              field_chars_next     = '0;
              fraction_digits_next = '0;
            end
          end else begin
            header_progress_next = (byte_value == CH_DOLLAR) ? 3'd1 : 3'd0;
          end
        end
      end else if (field_number != FIELD_DONE) begin
        if (byte_value == CH_NUL || byte_value == CH_COMMA) begin
          if (lat_short) begin
            lat_degrees_next    = '0;
            lat_minutes_e5_next = '0;
          end
          if (lon_short) begin
            lon_degrees_next    = '0;
            lon_minutes_e5_next = '0;
          end
          if (byte_value == CH_NUL) begin
            field_number_next = FIELD_DONE;
          end else begin
            if (field_number < FIELD_LAST) begin
              field_number_next = field_number + 4'd1;
            end
            field_chars_next     = '0;
            fraction_digits_next = '0;
          end
        end else begin
          if (field_number == FIELD_LAT || field_number == FIELD_LON) begin
            if (field_chars == 4'd4) begin
              fraction_digits_next = head_f3.fd;
              if (field_number == FIELD_LAT) begin
                lat_degrees_next    = deg_calc;
                lat_minutes_e5_next = head_f3.acc;
              end else begin
                lon_degrees_next    = deg_calc;
                lon_minutes_e5_next = head_f3.acc;
              end
            end else if (field_chars > 4'd4) begin
              fraction_digits_next = feed_cur.fd;
              if (field_number == FIELD_LAT) begin
                lat_minutes_e5_next = feed_cur.acc;
              end else begin
                lon_minutes_e5_next = feed_cur.acc;
              end
            end
          end else if (field_number == FIELD_NS) begin
            if (field_chars == 4'd0 && byte_value == CH_S) begin
              south_next = 1'b1;
            end
          end else if (field_number == FIELD_EW) begin
            if (field_chars == 4'd0 && byte_value == CH_W) begin
              west_next = 1'b1;
            end
          end else if (field_number == FIELD_ALT && fraction_digits != FD_STOP) begin
            if (field_chars == 4'd0 && (byte_value == CH_MINUS || byte_value == CH_PLUS)) begin
              altitude_negative_next = (byte_value == CH_MINUS);
            end else if (is_digit(byte_value)) begin
              if (fraction_digits == 3'd0) begin
                alt_v = 31'(altitude_accum) * 31'd10 + 31'(byte_value[3:0]) * 31'd1000;
              end else if (fraction_digits <= 3'd3) begin
                alt_v = 31'(altitude_accum) + 31'(byte_value[3:0]) * alt_w;
                fraction_digits_next = fraction_digits + 3'd1;
              end
              altitude_accum_next = (alt_v > 31'(ALT_SAT)) ? ALT_SAT
                                                           : alt_v[ggp_pkg::ALT_MAG_W-1:0];
            end else if (byte_value == CH_DOT && fraction_digits == 3'd0) begin
              fraction_digits_next = 3'd1;
            end else begin
              fraction_digits_next = FD_STOP;
            end
          end
          if (field_chars != CHARS_MAX) begin
            field_chars_next = field_chars + 4'd1;
          end
        end
      end
    end

    if (accept && op_tick && burst_bytes != '0) begin
      if (idle_ticks < idle_limit) begin
        idle_ticks_next = idle_ticks + ggp_pkg::LIMIT_W'(1);
      end else begin
        // Burst complete: report the fix if the header was seen, then start over.
        emit                   = header_found;
        burst_bytes_next       = '0;
        idle_ticks_next        = '0;
        header_progress_next   = '0;
        header_found_next      = 1'b0;
        field_number_next      = '0;
        field_chars_next       = '0;
        lat_degrees_next       = '0;
        lat_minutes_e5_next    = '0;
        lon_degrees_next       = '0;
        lon_minutes_e5_next    = '0;
        south_next             = 1'b0;
        west_next              = 1'b0;
        altitude_accum_next    = '0;
        altitude_negative_next = 1'b0;
        fraction_digits_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_bytes       <= '0;
      idle_ticks        <= '0;
      header_progress   <= '0;
      header_found      <= 1'b0;
      field_number      <= '0;
      field_chars       <= '0;
      lat_degrees       <= '0;
      lat_minutes_e5    <= '0;
      lon_degrees       <= '0;
      lon_minutes_e5    <= '0;
      south             <= 1'b0;
      west              <= 1'b0;
      altitude_accum    <= '0;
      altitude_negative <= 1'b0;
      fraction_digits   <= '0;
    end else begin
      burst_bytes       <= burst_bytes_next;
      idle_ticks        <= idle_ticks_next;
      header_progress   <= header_progress_next;
      header_found      <= header_found_next;
      field_number      <= field_number_next;
      field_chars       <= field_chars_next;
      lat_degrees       <= lat_degrees_next;
      lat_minutes_e5    <= lat_minutes_e5_next;
      lon_degrees       <= lon_degrees_next;
      lon_minutes_e5    <= lon_minutes_e5_next;
      south             <= south_next;
      west              <= west_next;
      altitude_accum    <= altitude_accum_next;
      altitude_negative <= altitude_negative_next;
      fraction_digits   <= fraction_digits_next;
    end
  end

  // The first four characters of a coordinate field are always rewritten
  // before they are read, so they need no reset.
  always_ff @(posedge clk) begin
    if (parse_byte && header_found && field_chars < 4'd4) begin
      coord_head[field_chars[1:0]] <= byte_value;
    end
  end

endmodule

FILE: rtl/core/ggp_result.sv
// Five-stage result pipeline: scales degrees and minutes to 1e-7 degree,
// saturates and applies hemisphere and altitude signs. Depends on ggp_pkg.
module ggp_result (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ggp_pkg::fix_t                fix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ggp_pkg::LAT_W-1:0]    latitude_e7,
  output logic [ggp_pkg::LON_W-1:0]    longitude_e7,
  output logic [ggp_pkg::ALT_W-1:0]    altitude_mm
);

  localparam logic [34:0] LAT_LIMIT = 35'd900000000;
  localparam logic [34:0] LON_LIMIT = 35'd1800000000;
  localparam logic [33:0] DEG_SCALE = 34'd10000000;
  // ceil(2^29 / 3); exact division by three for every dividend below 2^29.
  localparam logic [55:0] RECIP3    = 56'd178956971;
  localparam int          RECIP3_SH = 29;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4, adv5;

  ggp_pkg::fix_t s1;

  logic [33:0] s2_lat_e7, s2_lon_e7;
  logic [26:0] s2_lat_m5, s2_lon_m5;
  logic        s2_south, s2_west, s2_alt_neg;
  logic [ggp_pkg::ALT_MAG_W-1:0] s2_alt;

  logic [33:0] s3_lat_e7, s3_lon_e7;
  logic [24:0] s3_lat_q, s3_lon_q;
  logic        s3_south, s3_west, s3_alt_neg;
  logic [ggp_pkg::ALT_MAG_W-1:0] s3_alt;

  logic [34:0] s4_lat_sum, s4_lon_sum;
  logic        s4_south, s4_west, s4_alt_neg;
  logic [ggp_pkg::ALT_MAG_W-1:0] s4_alt;

  logic [55:0] lat_prod, lon_prod;
  logic [30:0] lat_mag;
  logic [31:0] lon_mag;
  logic [ggp_pkg::ALT_W-1:0] alt_ext;

  assign adv5     = !out_valid || out_ready;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign lat_prod = 56'(s2_lat_m5) * RECIP3;
  assign lon_prod = 56'(s2_lon_m5) * RECIP3;

  assign lat_mag = (s4_lat_sum > LAT_LIMIT) ? LAT_LIMIT[30:0] : s4_lat_sum[30:0];
  assign lon_mag = (s4_lon_sum > LON_LIMIT) ? LON_LIMIT[31:0] : s4_lon_sum[31:0];
  assign alt_ext = ggp_pkg::ALT_W'(s4_alt);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1 <= fix;
    end
    // Rounded minutes/60 in 1e-7 degree is (min_e5 * 5 + 1) / 3.
    if (adv2) begin
      s2_lat_e7  <= 34'(s1.lat_deg) * DEG_SCALE;
      s2_lon_e7  <= 34'(s1.lon_deg) * DEG_SCALE;
      s2_lat_m5  <= 27'(s1.lat_min) * 27'd5 + 27'd1;
      s2_lon_m5  <= 27'(s1.lon_min) * 27'd5 + 27'd1;
      s2_south   <= s1.south;
      s2_west    <= s1.west;
      s2_alt     <= s1.alt_mag;
      s2_alt_neg <= s1.alt_neg;
    end
    if (adv3) begin
      s3_lat_e7  <= s2_lat_e7;
      s3_lon_e7  <= s2_lon_e7;
      s3_lat_q   <= lat_prod[RECIP3_SH +: 25];
      s3_lon_q   <= lon_prod[RECIP3_SH +: 25];
      s3_south   <= s2_south;
      s3_west    <= s2_west;
      s3_alt     <= s2_alt;
      s3_alt_neg <= s2_alt_neg;
    end
    if (adv4) begin
      s4_lat_sum <= 35'(s3_lat_e7) + 35'(s3_lat_q);
      s4_lon_sum <= 35'(s3_lon_e7) + 35'(s3_lon_q);
      s4_south   <= s3_south;
      s4_west    <= s3_west;
      s4_alt     <= s3_alt;
      s4_alt_neg <= s3_alt_neg;
    end
    if (adv5) begin
      latitude_e7  <= s4_south ? -lat_mag : lat_mag;
      longitude_e7 <= s4_west ? -lon_mag : lon_mag;
      altitude_mm  <= s4_alt_neg ? -alt_ext : alt_ext;
    end
  end

endmodule

FILE: rtl/core/nmea_gga_position_parser.sv
// A completing tick's result passes s1 to s4 and the output register before m_tvalid.
// Throughput: one byte or tick per cycle; the parser state updates as each item is taken
// and the result pipeline holds up to five fixes, stalling input only when it is full.
// Reset: synchronous, active high; clears burst state but coord_head; idle_limit is 50.
// Top level of the GGA position parser: configuration register, parser and
// result pipeline. Depends on ggp_pkg, ggp_parser and ggp_result.
module nmea_gga_position_parser #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // [0] op: 0 byte, 1 millisecond tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [30:0] latitude_e7, [62:31] longitude_e7,
                                 // [90:63] altitude_mm, [95:91] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ggp_pkg::LIMIT_W-1:0] idle_limit;
  logic                        accept;
  logic                        emit;
  ggp_pkg::fix_t               fix;
  logic [ggp_pkg::LAT_W-1:0]   latitude_e7;
  logic [ggp_pkg::LON_W-1:0]   longitude_e7;
  logic [ggp_pkg::ALT_W-1:0]   altitude_mm;

  assign pready = 1'b1;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= ggp_pkg::IDLE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ggp_pkg::ADDR_IDLE_LIMIT[2]) begin
      idle_limit <= pwdata[ggp_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ggp_pkg::ADDR_IDLE_LIMIT[2]) ? 32'(idle_limit) : '0;

  ggp_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op_tick    (s_tuser),
    .byte_value (s_tdata),
    .idle_limit (idle_limit),
    .emit       (emit),
    .fix        (fix)
  );

  ggp_result u_result (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (emit),
    .in_ready     (s_tready),
    .fix          (fix),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .latitude_e7  (latitude_e7),
    .longitude_e7 (longitude_e7),
    .altitude_mm  (altitude_mm)
  );

  assign m_tdata = {5'b0, altitude_mm, longitude_e7, latitude_e7};

  // A result is launched only by an accepted tick transaction.
  a_emit_on_tick: assert property (@(posedge clk) disable iff (rst)
    emit |-> (s_tvalid && s_tready && s_tuser))
    else $error("result launched without an accepted tick");

  // With the output register empty the whole pipeline can move, so s_tready is high.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output is empty");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");

endmodule

FILE: dv/nmea_gga_position_parser_tb.sv
// Self-checking testbench for nmea_gga_position_parser: streams GGA sentences, noise and
// millisecond ticks, predicts every position fix and checks each one field by field.
// Depends on ggp_pkg and the nmea_gga_position_parser RTL.
module nmea_gga_position_parser_tb;

  localparam int BUF_BYTES       = 128;
  localparam int SETTLE_CYCLES   = 12;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int LONG_HOLD       = 1500;
  localparam int RANDOM_ITEMS    = 400;

  localparam bit OP_BYTE = 1'b0;
  localparam bit OP_TICK = 1'b1;

  localparam int HDR_LEN   = 7;
  localparam int FLD_LAT   = 2;
  localparam int FLD_NS    = 3;
  localparam int FLD_LON   = 4;
  localparam int FLD_EW    = 5;
  localparam int FLD_ALT   = 9;
  localparam int FLD_LAST  = 14;
  localparam int FLD_DONE  = 15;
  localparam int FRAC_INT  = 0;
  localparam int FRAC_STOP = 7;

  localparam longint LAT_LIMIT = 900000000;
  localparam longint LON_LIMIT = 1800000000;
  localparam longint ALT_LIMIT = 100000000;

  typedef struct {
    longint lat;
    longint lon;
    longint alt;
  } position_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_value
  logic        s_tuser = 1'b0;    // [0] op: 0 byte, 1 millisecond tick
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;           // [30:0] latitude_e7, [62:31] longitude_e7,
                                  // [90:63] altitude_mm, [95:91] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nmea_gga_position_parser #(.BUFFER_BYTES(BUF_BYTES)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Parser state as the block should hold it.
  int unsigned idle_lim;
  int unsigned burst_len, quiet_ticks, hdr_match, field_idx, field_len, frac_state;
  bit          hdr_seen, south, west, alt_neg;
  logic [7:0]  coord_chars [5];
  int unsigned lat_deg, lat_min, lon_deg, lon_min, alt_acc;
  string       gga_header = "$GPGGA,";

  position_t   pending_fixes[$];
  int          errors = 0;
  int          item_count = 0;
  int          useful_items = 0;
  int          fixes_made = 0;
  int          fix_count = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  int          long_hold_req = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int unsigned pow10(int unsigned n);
    int unsigned p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  task automatic clear_burst();
    burst_len = 0; quiet_ticks = 0; hdr_match = 0; hdr_seen = 0;
    field_idx = 0; field_len = 0; coord_chars = '{default: 8'h00};
    lat_deg = 0; lat_min = 0; lon_deg = 0; lon_min = 0;
    south = 0; west = 0; alt_acc = 0; alt_neg = 0; frac_state = FRAC_INT;
  endtask

  // Minutes carry five fraction digits; frac_state counts the point and the digits after it.
  function automatic int unsigned feed_minutes(int unsigned acc, logic [7:0] c);
    longint unsigned v;
    int unsigned d;
    v = acc;
    if (frac_state == FRAC_STOP) return acc;
    if (is_num(c)) begin
      d = c - 8'h30;
      if (frac_state == FRAC_INT) begin
        v = v * 10 + d * 100000;
      end else if (frac_state <= 5) begin
        v = v + d * pow10(5 - frac_state);
        frac_state++;
      end
      if (v > 64'hFFFFFF) v = 64'hFFFFFF;
      return int'(v);
    end else if (c == "." && frac_state == FRAC_INT) begin
      frac_state = 1;
    end else begin
      frac_state = FRAC_STOP;
    end
    return acc;
  endfunction

  task automatic take_coord_char(bit is_lat, logic [7:0] c);
    int unsigned deg, mins, n, i;
    deg = is_lat ? lat_deg : lon_deg;
    mins = is_lat ? lat_min : lon_min;
    if (field_len < 5) coord_chars[field_len] = c;
    if (field_len == 4) begin
      // The fifth character tells whether the degrees have two digits or three.
      n = (c == ".") ? 2 : 3;
      deg = 0;
      for (i = 0; i < n && is_num(coord_chars[i]); i++) deg = deg * 10 + (coord_chars[i] - 8'h30);
      mins = 0;
      frac_state = FRAC_INT;
      for (i = n; i < 5; i++) mins = feed_minutes(mins, coord_chars[i]);
    end else if (field_len > 4) begin
      mins = feed_minutes(mins, c);
    end
    if (is_lat) begin
      lat_deg = deg; lat_min = mins;
    end else begin
      lon_deg = deg; lon_min = mins;
    end
  endtask

  task automatic take_alt_char(logic [7:0] c);
    longint unsigned v;
    int unsigned d;
    v = alt_acc;
    if (frac_state == FRAC_STOP) return;
    if (field_len == 0 && (c == "-" || c == "+")) begin
      alt_neg = (c == "-");
      return;
    end
    if (is_num(c)) begin
      d = c - 8'h30;
      if (frac_state == FRAC_INT) begin
        v = v * 10 + d * 1000;
      end else if (frac_state <= 3) begin
        v = v + d * pow10(3 - frac_state);
        frac_state++;
      end
      if (v > ALT_LIMIT) v = ALT_LIMIT;
      alt_acc = int'(v);
    end else if (c == "." && frac_state == FRAC_INT) begin
      frac_state = 1;
    end else begin
      frac_state = FRAC_STOP;
    end
  endtask

  task automatic close_field();
    if (field_idx == FLD_LAT && field_len <= 5) begin
      lat_deg = 0; lat_min = 0;
    end
    if (field_idx == FLD_LON && field_len <= 5) begin
      lon_deg = 0; lon_min = 0;
    end
  endtask

  task automatic parse_char(logic [7:0] c);
    if (!hdr_seen) begin
      if (hdr_match == HDR_LEN) return;
      if (c == 8'h00) begin
        hdr_match = HDR_LEN;
        return;
      end
      if (c == gga_header[hdr_match]) begin
        hdr_match++;
        if (hdr_match == HDR_LEN) begin
          hdr_seen = 1; field_idx = 1; field_len = 0; frac_state = FRAC_INT;
        end
      end else begin
        hdr_match = (c == "$") ? 1 : 0;
      end
      return;
    end
    if (field_idx == FLD_DONE) return;
    if (c == 8'h00) begin
      close_field();
      field_idx = FLD_DONE;
      return;
    end
    if (c == ",") begin
      close_field();
      if (field_idx < FLD_LAST) field_idx++;
      field_len = 0;
      frac_state = FRAC_INT;
      return;
    end
    if (field_idx == FLD_LAT) take_coord_char(1'b1, c);
    else if (field_idx == FLD_LON) take_coord_char(1'b0, c);
    else if (field_idx == FLD_NS && field_len == 0 && c == "S") south = 1;
    else if (field_idx == FLD_EW && field_len == 0 && c == "W") west = 1;
    else if (field_idx == FLD_ALT) take_alt_char(c);
    if (field_len < 15) field_len++;
  endtask

  function automatic longint coord_e7(int unsigned deg, int unsigned mins, bit neg,
                                      longint lim);
    longint v;
    v = longint'(deg) * 10000000 + (longint'(mins) * 5 + 1) / 3;
    if (v > lim) v = lim;
    return neg ? -v : v;
  endfunction

  // Applies one accepted transaction to the parser state and queues any fix it completes.
  task automatic advance_parser(bit op, logic [7:0] c);
    position_t fix;
    if (op == OP_BYTE || burst_len != 0) useful_items++;
    if (op == OP_BYTE) begin
      quiet_ticks = 0;
      if (burst_len < BUF_BYTES - 2) begin
        burst_len++;
        parse_char(c);
      end
    end else if (burst_len != 0) begin
      if (quiet_ticks < idle_lim) begin
        quiet_ticks++;
      end else begin
        if (hdr_seen) begin
          close_field();
          fix.lat = coord_e7(lat_deg, lat_min, south, LAT_LIMIT);
          fix.lon = coord_e7(lon_deg, lon_min, west, LON_LIMIT);
          fix.alt = alt_neg ? -longint'(alt_acc) : longint'(alt_acc);
          pending_fixes.push_back(fix);
          fixes_made++;
        end
        clear_burst();
      end
    end
  endtask

  task automatic send_item(bit op, logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= c;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    advance_parser(op, c);
    item_count++;
  endtask

  task automatic send_byte(logic [7:0] c);
    send_item(OP_BYTE, c);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noisy(string s, int pct);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 99) < pct) send_byte(8'($urandom_range(0, 255)));
      else send_byte(s[i]);
    end
  endtask

  task automatic send_text(string s);
    send_noisy(s, 0);
  endtask

  // Ticks until the current burst is complete.
  task automatic finish_burst();
    while (burst_len != 0) send_tick();
  endtask

  task automatic send_sentence(string s);
    send_text(s);
    finish_burst();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_limit(int unsigned value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ggp_pkg::ADDR_IDLE_LIMIT; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    idle_lim = value & 32'h3FF;
    @(posedge clk);
  endtask

  task automatic check_idle_limit_reg();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ggp_pkg::ADDR_IDLE_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[ggp_pkg::LIMIT_W-1:0] !== idle_lim[ggp_pkg::LIMIT_W-1:0]) begin
      $error("idle_limit mismatch: expected %0d, actual %0d", idle_lim,
             prdata[ggp_pkg::LIMIT_W-1:0]);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic string rand_coord(int deg_digits);
    case ($urandom_range(0, 7))
      0: return "";
      1: return rand_digits($urandom_range(1, 5));
      2: return {rand_digits(deg_digits + 2), $sformatf("%c", $urandom_range(33, 126)),
                 rand_digits(3)};
      3: return rand_digits($urandom_range(deg_digits + 3, 12));
      default: return {rand_digits(deg_digits + 2), ".", rand_digits($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic string rand_hemi(string plus, string minus);
    case ($urandom_range(0, 4))
      0: return "";
      1: return plus;
      2: return minus;
      3: return {minus, "x"};
      default: return $sformatf("%c", $urandom_range(33, 126));
    endcase
  endfunction

  function automatic string rand_altitude();
    string s;
    s = "";
    case ($urandom_range(0, 3))
      0: s = "-";
      1: s = "+";
      default: ;
    endcase
    s = {s, rand_digits($urandom_range(0, 10))};
    if ($urandom_range(0, 2) != 0) s = {s, ".", rand_digits($urandom_range(0, 5))};
    return s;
  endfunction

  function automatic string rand_sentence();
    return {"$GPGGA,", rand_digits(6), ".00,", rand_coord(2), ",", rand_hemi("N", "S"), ",",
            rand_coord(3), ",", rand_hemi("E", "W"), ",1,", rand_digits(2), ",0.9,",
            rand_altitude(), ",M,46.9,M,,*", rand_digits(2), "\015\n"};
  endfunction

  task automatic test_reset_value();
    idle_lim = ggp_pkg::IDLE_LIMIT_RESET;
    check_idle_limit_reg();
    send_sentence("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n");
    drain();
  endtask

  task automatic test_field_cases();
    write_idle_limit(2);
    check_idle_limit_reg();
    repeat (3) send_tick();
    send_sentence("$GPGGA,,3352.12345,S,15112.56789,W,1,,,-12.3456,M,,M,,*00");
    send_sentence("$GPGGA,,9959.999999,S,99959.99999,W,,,,+99999999.999,M");
    send_sentence("$GPGGA,,0000.00000,N,00000.00000,E,,,,0.000");
    send_sentence("$GPGGA,,1299999999.9,N,12399999999,E,,,,999999999999");
    send_sentence("$GPGGA,,12.3,,1234,,,,,,");
    send_sentence("$GPGGA,,48a7.5x,Nord,0113b.0,West,,,,12.3.4");
    send_sentence("$GPGGA,,4807.5,S1,,W,,,,-");
    send_sentence("$$GPGG$GPGGA,,0100.0,N,,,,,,5.5");
    send_sentence("$GPRMC,,4807.038,N");
    // A zero byte ends the parseable text, both after the header and before it.
    send_text("$GPGGA,,4807.038");
    send_byte(8'h00);
    send_sentence(",S,01131.000,W");
    send_byte(8'h00);
    send_sentence("$GPGGA,,4807.038,N");
    send_sentence("$GPGGA,,1111.1,N\015\n$GPGGA,,2222.2,S,,,,,,7\015\n");
    // Overlong burst: the latitude straddles the point where bytes start being dropped.
    send_text("$GPGGA,");
    repeat (110) send_byte("Z");
    send_sentence(",1234.5678,S");
    send_text("$GPGGA,,12");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_sentence("34.5,N,,,,,,,1.5");
    drain();
  endtask

  task automatic test_idle_limit_extremes();
    write_idle_limit(0);
    check_idle_limit_reg();
    send_sentence("$GPGGA,,0130.5,S,00245.25,W,,,,3.5");
    drain();
    write_idle_limit(1000);
    check_idle_limit_reg();
    send_sentence("$GPGGA,,8959.99999,N,17959.99999,E,,,,-0.001");
    drain();
    write_idle_limit(1);
    send_sentence("$GPGGA,,4500.0,S,09000.0,W,,,,100");
    drain();
  endtask

  task automatic test_output_backpressure();
    write_idle_limit(0);
    steady = 1'b1;
    long_hold_req = LONG_HOLD;
    repeat (12) send_sentence("$GPGGA,,0130.5,S,00245.25,W,,,,3.5");
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start_items, bursts, kind;
    string s;
    start_items = useful_items;
    bursts = 0;
    while (useful_items - start_items < RANDOM_ITEMS) begin
      if (bursts % 12 == 0) begin
        drain();
        case ($urandom_range(0, 5))
          0: write_idle_limit(0);
          1: write_idle_limit(1);
          2: write_idle_limit(2);
          3: write_idle_limit(3);
          4: write_idle_limit(7);
          default: write_idle_limit($urandom_range(4, 20));
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 15);
      if (kind < 9) begin
        send_text(rand_sentence());
      end else if (kind < 11) begin
        send_noisy(rand_sentence(), 3);
      end else if (kind == 11) begin
        send_text({rand_sentence(), rand_sentence()});
      end else if (kind == 12) begin
        s = rand_sentence();
        send_text(s.substr(0, $urandom_range(0, s.len() - 1)));
        send_byte(8'h00);
        send_text(rand_sentence());
      end else if (kind == 13) begin
        repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind == 14) begin
        send_text({"$GPGG", rand_sentence()});
      end else begin
        repeat ($urandom_range(1, 5)) send_tick();
      end
      // Now and then the silence is too short and the next burst runs on.
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(0, idle_lim)) send_tick();
      else finish_burst();
      bursts++;
    end
    finish_burst();
    drain();
    steady = 1'b0;
  endtask

  // Receiver: short random stalls, a long hold when requested, none in steady stretches.
  always @(posedge clk) begin
    if (long_hold_req != 0) begin
      hold_left = long_hold_req;
      long_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 12);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Handshake signals only change at rising edges, so a transaction seen here completes
  // at the next edge.
  always @(negedge clk) begin
    position_t want;
    longint got_lat, got_lon, got_alt;
    if (!rst && m_tvalid && m_tready) begin
      got_lat = $signed(m_tdata[30:0]);
      got_lon = $signed(m_tdata[62:31]);
      got_alt = $signed(m_tdata[90:63]);
      if (pending_fixes.size() == 0) begin
        $error("position fix with none expected: %h", m_tdata);
        errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (got_lat != want.lat) begin
          $error("latitude_e7 mismatch: expected %0d, actual %0d", want.lat, got_lat);
          errors++;
        end
        if (got_lon != want.lon) begin
          $error("longitude_e7 mismatch: expected %0d, actual %0d", want.lon, got_lon);
          errors++;
        end
        if (got_alt != want.alt) begin
          $error("altitude_mm mismatch: expected %0d, actual %0d", want.alt, got_alt);
          errors++;
        end
        if (m_tdata[95:91] !== 5'd0) begin
          $error("padding mismatch: expected 0, actual %0h", m_tdata[95:91]);
          errors++;
        end
      end
      fix_count++;
    end
  end

  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Timeout after %0d cycles without a transaction", quiet_cycles);
      $display("nmea_gga_position_parser verification failed");
      $finish;
    end
  end

  initial begin
    clear_burst();
    idle_lim = ggp_pkg::IDLE_LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_value();
    test_field_cases();
    test_idle_limit_extremes();
    test_output_backpressure();
    test_random_traffic();
    drain();
    $display("Sent %0d input transactions (%0d that matter) and checked %0d position fixes,",
             item_count, useful_items, fix_count);
    $display("with idle limits from 0 to 1000, overlong bursts, noise and output back-pressure.");
    if (errors == 0) begin
      $display("nmea_gga_position_parser verification clean");
    end else begin
      $display("nmea_gga_position_parser verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ggp_pkg.sv
rtl/core/ggp_parser.sv
rtl/core/ggp_result.sv
rtl/core/nmea_gga_position_parser.sv
dv/nmea_gga_position_parser_tb.sv
